@@ hdl/assert_macros.svh @@
// Concurrent assertion macros for the RTL top level.
// Expects clk and rst_n in scope at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

@@ hdl/gpsp_pkg.sv @@
// Shared types and constants for the game pad serial poller.
// No dependencies.
`default_nettype none
package gpsp_pkg;

  localparam int WORD_BITS = 16;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LATCH_TICKS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_TICKS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MGAP_TICKS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_TICKS = 3'd4;

  typedef struct packed {
    logic        enable;
    logic [7:0]  latch_ticks;
    logic [7:0]  half_period_ticks;
    logic [7:0]  mouse_gap_ticks;
    logic [15:0] frame_ticks;
  } cfg_t;

  typedef struct packed {
    logic [11:0] buttons;
    logic [15:0] pad_word;
    logic        mouse_present;
    logic        moving_up;
    logic [6:0]  vertical_amount;
    logic        moving_left;
    logic [6:0]  horizontal_amount;
  } report_t;

  typedef struct packed {
    logic    latch_pin;
    logic    clock_pin;
    logic    report_valid;
    report_t report;
  } result_t;

endpackage
`default_nettype wire

@@ hdl/game_pad_serial_poller_core.sv @@
// Top level of the game pad serial poller: config registers, output register.
// Depends on gpsp_pkg, gpsp_seq and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
// Each input transfer is one time tick carrying the data pin level; each tick
// yields exactly one result transfer with the latch and clock pin levels for
// that tick and the last completed poll report (report_valid marks the tick a
// new report completes). The block takes one tick per clock cycle while in_stall
// is low; the phase machine and timers advance on each tick taken, and the result
// is registered in the cycle after the tick is taken. in_stall is high only while
// a result waits in that register and out_stall holds it. Configuration
// writes are always ready and should be made while no tick is outstanding;
// frame_ticks sets the poll cadence in ticks from one poll start to the next.
module game_pad_serial_poller_core import gpsp_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 in_data_line,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      out_latch_pin,
  output logic                      out_clock_pin,
  output logic                      out_report_valid,
  output logic [11:0]               out_buttons,
  output logic [15:0]               out_pad_word,
  output logic                      out_mouse_present,
  output logic                      out_moving_up,
  output logic [6:0]                out_vertical_amount,
  output logic                      out_moving_left,
  output logic [6:0]                out_horizontal_amount,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0]          cfg_data
);

  cfg_t    cfg_r;
  result_t res;
  result_t out_r;
  logic    out_valid_r;
  logic    accept;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r & out_stall;
  assign accept    = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable            <= 1'b1;
      cfg_r.latch_ticks       <= 8'd12;
      cfg_r.half_period_ticks <= 8'd6;
      cfg_r.mouse_gap_ticks   <= 8'd3;
      cfg_r.frame_ticks       <= 16'd16667;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ENABLE:      cfg_r.enable            <= cfg_data[0];
        CFG_LATCH_TICKS: cfg_r.latch_ticks       <= cfg_data[7:0];
        CFG_HALF_TICKS:  cfg_r.half_period_ticks <= cfg_data[7:0];
        CFG_MGAP_TICKS:  cfg_r.mouse_gap_ticks   <= cfg_data[7:0];
        CFG_FRAME_TICKS: cfg_r.frame_ticks       <= cfg_data;
        default: ;
      endcase
    end
  end

  gpsp_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (accept),
    .pressed (~in_data_line),
    .cfg     (cfg_r),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_r <= res;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_latch_pin         = out_r.latch_pin;
  assign out_clock_pin         = out_r.clock_pin;
  assign out_report_valid      = out_r.report_valid;
  assign out_buttons           = out_r.report.buttons;
  assign out_pad_word          = out_r.report.pad_word;
  assign out_mouse_present     = out_r.report.mouse_present;
  assign out_moving_up         = out_r.report.moving_up;
  assign out_vertical_amount   = out_r.report.vertical_amount;
  assign out_moving_left       = out_r.report.moving_left;
  assign out_horizontal_amount = out_r.report.horizontal_amount;

  `ASSERT_CLK(a_accept_gives_result, accept |=> out_valid, "accepted tick gave no result")
  `ASSERT_NEVER(a_latch_clock_overlap, out_valid && out_latch_pin && !out_clock_pin, "latch during clock low")
  `ASSERT_CLK(a_report_lines_idle, (out_valid && out_report_valid) |-> (!out_latch_pin && out_clock_pin), "report tick with lines busy")
  `ASSERT_CLK(a_no_mouse_zero, (out_valid && !out_mouse_present) |-> (out_vertical_amount == 7'd0 && out_horizontal_amount == 7'd0 && !out_moving_up && !out_moving_left), "mouse fields set without mouse")

endmodule
`default_nettype wire

@@ hdl/gpsp_seq.sv @@
// Poll sequencer: phase machine, tick timers, shift registers, held report.
// Depends on gpsp_pkg.
`default_nettype none
module gpsp_seq import gpsp_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    step,
  input  wire logic    pressed,
  input  wire cfg_t    cfg,
  output result_t      res
);

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_LATCH = 3'd1;
  localparam logic [2:0] PH_GAP   = 3'd2;
  localparam logic [2:0] PH_LOW   = 3'd3;
  localparam logic [2:0] PH_HIGH  = 3'd4;
  localparam logic [2:0] PH_MGAP  = 3'd5;

  logic [2:0]  phase_r, phase_nxt;
  logic [7:0]  phase_timer_r, phase_timer_nxt;
  logic [15:0] frame_timer_r, frame_timer_nxt;
  logic [4:0]  bit_count_r, bit_count_nxt;
  logic [15:0] pad_shift_r, pad_shift_nxt;
  logic [15:0] mouse_shift_r, mouse_shift_nxt;
  report_t     held_r, held_nxt;

  logic        last;
  logic [7:0]  hp;
  logic        latch_o, clock_o, valid_o;

  function automatic report_t build_report(logic [15:0] pad, logic [15:0] mouse);
    report_t     r;
    logic [15:0] m;
    m = pad[0] ? mouse : 16'h0000;
    for (int k = 0; k < 12; k++) begin
      r.buttons[k] = pad[15-k];
    end
    r.pad_word          = pad;
    r.mouse_present     = pad[0];
    r.moving_up         = m[15];
    r.vertical_amount   = m[14:8];
    r.moving_left       = m[7];
    r.horizontal_amount = m[6:0];
    return r;
  endfunction

  assign hp = (cfg.half_period_ticks == 8'd0) ? 8'd1 : cfg.half_period_ticks;

  always_comb begin
    phase_nxt       = phase_r;
    phase_timer_nxt = phase_timer_r;
    frame_timer_nxt = frame_timer_r;
    bit_count_nxt   = bit_count_r;
    pad_shift_nxt   = pad_shift_r;
    mouse_shift_nxt = mouse_shift_r;
    held_nxt        = held_r;
    latch_o         = 1'b0;
    clock_o         = 1'b1;
    valid_o         = 1'b0;
    last            = 1'b0;
    if (!cfg.enable) begin
      phase_nxt       = PH_IDLE;
      phase_timer_nxt = 8'd0;
      frame_timer_nxt = 16'd0;
      bit_count_nxt   = 5'd0;
    end else begin
      // frame start, period counted start to start
      if (phase_r == PH_IDLE && frame_timer_r == 16'd0) begin
        phase_nxt       = PH_LATCH;
        phase_timer_nxt = (cfg.latch_ticks == 8'd0) ? 8'd1 : cfg.latch_ticks;
        frame_timer_nxt = ((cfg.frame_ticks == 16'd0) ? 16'd1 : cfg.frame_ticks) - 16'd1;
        bit_count_nxt   = 5'd0;
        pad_shift_nxt   = 16'h0000;
        mouse_shift_nxt = 16'h0000;
      end else if (frame_timer_r != 16'd0) begin
        frame_timer_nxt = frame_timer_r - 16'd1;
      end

      if (phase_nxt != PH_IDLE) begin
        last = (phase_timer_nxt <= 8'd1);
        if (phase_nxt == PH_LATCH) latch_o = 1'b1;
        if (phase_nxt == PH_LOW) begin
          clock_o = 1'b0;
          // sample just before the rising edge
          if (last) begin
            if (bit_count_nxt < 5'(WORD_BITS)) begin
              pad_shift_nxt = {pad_shift_nxt[14:0], pressed};
            end else begin
              mouse_shift_nxt = {mouse_shift_nxt[14:0], pressed};
            end
          end
        end
        if (!last) begin
          phase_timer_nxt = phase_timer_nxt - 8'd1;
        end else begin
          phase_timer_nxt = hp;
          unique case (phase_nxt)
            PH_LATCH: phase_nxt = PH_GAP;
            PH_GAP:   phase_nxt = PH_LOW;
            PH_LOW:   phase_nxt = PH_HIGH;
            PH_MGAP:  phase_nxt = PH_LOW;
            default: begin
              if (bit_count_nxt[3:0] != 4'hF) begin
                bit_count_nxt = bit_count_nxt + 5'd1;
                phase_nxt     = PH_LOW;
              end else if (bit_count_nxt == 5'd15 && pad_shift_nxt[0]) begin
                // mouse present: clock a second word
                bit_count_nxt = 5'd16;
                if (cfg.mouse_gap_ticks != 8'd0) begin
                  phase_nxt       = PH_MGAP;
                  phase_timer_nxt = cfg.mouse_gap_ticks;
                end else begin
                  phase_nxt = PH_LOW;
                end
              end else begin
                held_nxt        = build_report(pad_shift_nxt, mouse_shift_nxt);
                valid_o         = 1'b1;
                bit_count_nxt   = 5'd0;
                phase_nxt       = PH_IDLE;
                phase_timer_nxt = 8'd0;
              end
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      phase_timer_r <= 8'd0;
      frame_timer_r <= 16'd0;
      bit_count_r   <= 5'd0;
      pad_shift_r   <= 16'h0000;
      mouse_shift_r <= 16'h0000;
      held_r        <= '0;
    end else if (step) begin
      phase_r       <= phase_nxt;
      phase_timer_r <= phase_timer_nxt;
      frame_timer_r <= frame_timer_nxt;
      bit_count_r   <= bit_count_nxt;
      pad_shift_r   <= pad_shift_nxt;
      mouse_shift_r <= mouse_shift_nxt;
      held_r        <= held_nxt;
    end
  end

  assign res.latch_pin    = latch_o;
  assign res.clock_pin    = clock_o;
  assign res.report_valid = valid_o;
  assign res.report       = held_nxt;

endmodule
`default_nettype wire

@@ sim/tb_game_pad_serial_poller_core.sv @@
// Testbench for game_pad_serial_poller_core: random pad line ticks with random gaps,
// random result stalls, per-tick result checking against an in-bench poll predictor.
// Depends on gpsp_pkg and the RTL of the block only.
`timescale 1ns / 1ps
module tb_game_pad_serial_poller_core;
  import gpsp_pkg::*;

  localparam int unsigned IDLE_LIMIT = 500;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

  typedef enum logic [2:0] {ST_IDLE, ST_LATCH, ST_GAP, ST_LOW, ST_HIGH, ST_MGAP} poll_phase_t;

  typedef struct {
    logic        line;
    int unsigned gap;
    bit          drain;
  } tick_item_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_data_line = 1'b0;
  logic out_stall = 1'b0;
  logic cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_ENABLE;
  logic [15:0] cfg_data = 16'h0000;

  logic in_stall, out_valid, cfg_ready;
  logic out_latch_pin, out_clock_pin, out_report_valid;
  logic [11:0] out_buttons;
  logic [15:0] out_pad_word;
  logic out_mouse_present, out_moving_up, out_moving_left;
  logic [6:0] out_vertical_amount, out_horizontal_amount;

  game_pad_serial_poller_core u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_data_line         (in_data_line),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_latch_pin        (out_latch_pin),
    .out_clock_pin        (out_clock_pin),
    .out_report_valid     (out_report_valid),
    .out_buttons          (out_buttons),
    .out_pad_word         (out_pad_word),
    .out_mouse_present    (out_mouse_present),
    .out_moving_up        (out_moving_up),
    .out_vertical_amount  (out_vertical_amount),
    .out_moving_left      (out_moving_left),
    .out_horizontal_amount(out_horizontal_amount),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Poller shadow state
  cfg_t        reg_shadow = '{1'b1, 8'd12, 8'd6, 8'd3, 16'd16667};
  poll_phase_t phase = ST_IDLE;
  logic [7:0]  phase_left = '0;
  logic [15:0] frame_left = '0;
  logic [4:0]  bits_done = '0;
  logic [15:0] pad_sr = '0;
  logic [15:0] mouse_sr = '0;
  report_t     last_report = '0;

  tick_item_t  line_q[$];
  result_t     tick_out_q[$];

  bit          tick_sent = 1'b0;
  bit          res_taken = 1'b0;
  bit          gap_armed = 1'b0;
  int unsigned gap_left = 0;
  int unsigned hold_left = 0;
  int unsigned res_count = 0;
  bit          rx_quiet = 1'b0;
  int unsigned cfg_writes = 0;
  int unsigned err_count = 0;
  int unsigned idle_cycles = 0;

  // Advance the poller by one tick and return the pin levels and held report.
  function automatic result_t poll_tick(input logic line);
    result_t     r;
    logic        pressed;
    logic        at_end;
    logic [7:0]  hp;
    logic [15:0] m;
    r = '0;
    r.clock_pin = 1'b1;
    pressed = ~line;
    hp = (reg_shadow.half_period_ticks == 8'd0) ? 8'd1 : reg_shadow.half_period_ticks;
    if (!reg_shadow.enable) begin
      phase = ST_IDLE;
      phase_left = '0;
      frame_left = '0;
      bits_done = '0;
    end else begin
      if (phase == ST_IDLE && frame_left == 16'd0) begin
        phase = ST_LATCH;
        phase_left = (reg_shadow.latch_ticks == 8'd0) ? 8'd1 : reg_shadow.latch_ticks;
        frame_left = ((reg_shadow.frame_ticks == 16'd0) ? 16'd1 : reg_shadow.frame_ticks) - 16'd1;
        bits_done = '0;
        pad_sr = '0;
        mouse_sr = '0;
      end else if (frame_left != 16'd0) begin
        frame_left = frame_left - 16'd1;
      end
      if (phase != ST_IDLE) begin
        at_end = (phase_left <= 8'd1);
        if (phase == ST_LATCH) r.latch_pin = 1'b1;
        if (phase == ST_LOW) begin
          r.clock_pin = 1'b0;
          // sample just before the rising clock edge
          if (at_end) begin
            if (bits_done < WORD_BITS) pad_sr = {pad_sr[14:0], pressed};
            else mouse_sr = {mouse_sr[14:0], pressed};
          end
        end
        if (!at_end) begin
          phase_left = phase_left - 8'd1;
        end else begin
          phase_left = hp;
          case (phase)
            ST_LATCH: phase = ST_GAP;
            ST_GAP:   phase = ST_LOW;
            ST_LOW:   phase = ST_HIGH;
            ST_MGAP:  phase = ST_LOW;
            default: begin
              if (bits_done[3:0] != 4'hF) begin
                bits_done = bits_done + 5'd1;
                phase = ST_LOW;
              end else if (bits_done == 5'd15 && pad_sr[0]) begin
                // mouse attached: read a second word
                bits_done = 5'd16;
                if (reg_shadow.mouse_gap_ticks != 8'd0) begin
                  phase = ST_MGAP;
                  phase_left = reg_shadow.mouse_gap_ticks;
                end else begin
                  phase = ST_LOW;
                end
              end else begin
                m = pad_sr[0] ? mouse_sr : 16'h0000;
                for (int k = 0; k < 12; k++) last_report.buttons[k] = pad_sr[15-k];
                last_report.pad_word = pad_sr;
                last_report.mouse_present = pad_sr[0];
                last_report.moving_up = m[15];
                last_report.vertical_amount = m[14:8];
                last_report.moving_left = m[7];
                last_report.horizontal_amount = m[6:0];
                r.report_valid = 1'b1;
                bits_done = '0;
                phase = ST_IDLE;
                phase_left = '0;
              end
            end
          endcase
        end
      end
    end
    r.report = last_report;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got, input logic [15:0] want);
    err_count++;
    $display("mismatch %s: got %0h want %0h at result %0d", what, got, want, res_count);
  endtask

  task automatic compare_field(input string name, input logic [15:0] got, input logic [15:0] want);
    if (got !== want) report_mismatch(name, got, want);
  endtask

  // Sender: one tick per transfer, random gap before each
  always @(negedge clk) begin
    logic drive;
    tick_item_t head;
    drive = in_valid && !tick_sent;
    if (rst_n && !drive && line_q.size() != 0) begin
      if (!gap_armed) begin
        gap_left = line_q[0].gap;
        gap_armed = 1'b1;
      end
      if (gap_left != 0) begin
        gap_left--;
      end else if (!(line_q[0].drain && tick_out_q.size() != 0)) begin
        head = line_q.pop_front();
        in_data_line <= head.line;
        drive = 1'b1;
        gap_armed = 1'b0;
      end
    end
    in_valid <= drive;
  end

  // Receiver: random stall after each result, quiet stretches now and then
  always @(negedge clk) begin
    if (rst_n) begin
      if (res_taken) begin
        if (res_count % 40 == 0) rx_quiet = ($urandom_range(0, 2) == 0);
        hold_left = rx_quiet ? 0 : $urandom_range(0, 15);
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Monitor: check results first, then predict the tick taken at this edge
  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      tick_sent <= 1'b0;
      res_taken <= 1'b0;
    end else begin
      tick_sent <= in_valid && !in_stall;
      res_taken <= out_valid && !out_stall;
      if (out_valid && !out_stall) begin
        res_count++;
        if (tick_out_q.size() == 0) begin
          report_mismatch("result with none pending", out_pad_word, 16'h0000);
        end else begin
          want = tick_out_q.pop_front();
          compare_field("latch_pin", out_latch_pin, want.latch_pin);
          compare_field("clock_pin", out_clock_pin, want.clock_pin);
          compare_field("report_valid", out_report_valid, want.report_valid);
          compare_field("buttons", out_buttons, want.report.buttons);
          compare_field("pad_word", out_pad_word, want.report.pad_word);
          compare_field("mouse_present", out_mouse_present, want.report.mouse_present);
          compare_field("moving_up", out_moving_up, want.report.moving_up);
          compare_field("vertical_amount", out_vertical_amount, want.report.vertical_amount);
          compare_field("moving_left", out_moving_left, want.report.moving_left);
          compare_field("horizontal_amount", out_horizontal_amount,
                        want.report.horizontal_amount);
        end
      end
      if (in_valid && !in_stall) tick_out_q.push_back(poll_tick(in_data_line));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ENABLE:      reg_shadow.enable = cfg_data[0];
          CFG_LATCH_TICKS: reg_shadow.latch_ticks = cfg_data[7:0];
          CFG_HALF_TICKS:  reg_shadow.half_period_ticks = cfg_data[7:0];
          CFG_MGAP_TICKS:  reg_shadow.mouse_gap_ticks = cfg_data[7:0];
          CFG_FRAME_TICKS: reg_shadow.frame_ticks = cfg_data;
          default: ;
        endcase
        cfg_writes++;
      end
    end
  end

  // Watchdog on cycles with no transfer of any kind
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    int unsigned seen;
    seen = cfg_writes;
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(negedge clk); while (cfg_writes == seen);
    cfg_valid <= 1'b0;
  endtask

  // Wait until every tick is sent and every result has come back; the outer
  // check catches a tick launched on the very negedge the inner loop ended
  task automatic settle();
    do begin
      do @(negedge clk); while (line_q.size() != 0 || in_valid || tick_out_q.size() != 0);
      repeat (2) @(negedge clk);
    end while (line_q.size() != 0 || in_valid || tick_out_q.size() != 0);
  endtask

  task automatic queue_ticks(input int n);
    tick_item_t it;
    int hold_at;
    bit quiet;
    hold_at = $urandom_range(0, n - 1);
    quiet = 1'b0;
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) quiet = ($urandom_range(0, 2) == 0);
      it.line = $urandom_range(0, 1);
      it.gap = quiet ? 0 : $urandom_range(0, 15);
      it.drain = (i == hold_at);
      line_q.push_back(it);
    end
  endtask

  initial begin
    tick_item_t it;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: a poll starts on the first tick after reset, both line levels
    for (int i = 0; i < 25; i++) begin
      it.line = (i % 2 == 1) || (i > 18);
      it.gap = 0;
      it.drain = 1'b0;
      line_q.push_back(it);
    end
    queue_ticks(450);
    settle();

    // Fastest timing with frame overrun and no mouse gap
    write_reg(CFG_LATCH_TICKS, 16'd1);
    write_reg(CFG_HALF_TICKS, 16'd1);
    write_reg(CFG_MGAP_TICKS, 16'd0);
    write_reg(CFG_FRAME_TICKS, 16'd40);
    queue_ticks(250);
    settle();

    // Zero latch, half period and frame all count as one tick; longest mouse gap
    write_reg(CFG_LATCH_TICKS, 16'd0);
    write_reg(CFG_HALF_TICKS, 16'd0);
    write_reg(CFG_MGAP_TICKS, 16'd255);
    write_reg(CFG_FRAME_TICKS, 16'd0);
    write_reg(CFG_UNUSED_IDX, 16'hFFFF);
    queue_ticks(200);
    settle();

    // Disable mid-poll: lines idle, poll abandoned
    write_reg(CFG_ENABLE, 16'd0);
    queue_ticks(40);
    settle();

    write_reg(CFG_ENABLE, 16'd1);
    write_reg(CFG_LATCH_TICKS, 16'd255);
    write_reg(CFG_HALF_TICKS, 16'd1);
    write_reg(CFG_MGAP_TICKS, 16'd1);
    write_reg(CFG_FRAME_TICKS, 16'hFFFF);
    queue_ticks(300);
    settle();

    // brief disable clears the long frame count
    write_reg(CFG_ENABLE, 16'd0);
    queue_ticks(5);
    settle();
    write_reg(CFG_ENABLE, 16'd1);
    write_reg(CFG_LATCH_TICKS, 16'd2);
    write_reg(CFG_HALF_TICKS, 16'd255);
    write_reg(CFG_FRAME_TICKS, 16'd16667);
    queue_ticks(60);
    settle();

    write_reg(CFG_ENABLE, 16'd0);
    queue_ticks(5);
    settle();
    write_reg(CFG_ENABLE, 16'd1);
    write_reg(CFG_LATCH_TICKS, 16'd3);
    write_reg(CFG_HALF_TICKS, 16'd2);
    write_reg(CFG_MGAP_TICKS, 16'd3);
    write_reg(CFG_FRAME_TICKS, 16'd200);
    queue_ticks(150);
    settle();

    repeat (10) @(posedge clk);
    if (tick_out_q.size() != 0)
      report_mismatch("results never came", 16'(tick_out_q.size()), 16'h0000);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ game_pad_serial_poller_core.f @@
+incdir+hdl
hdl/gpsp_pkg.sv
hdl/gpsp_seq.sv
hdl/game_pad_serial_poller_core.sv
sim/tb_game_pad_serial_poller_core.sv
